// ===== rtl/core/awdm_pkg.sv =====
// Shared types, constants and codes for the area-weighted distortion metric block.
package awdm_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DIVW = 64 + 3 * FRAC_BITS;
    localparam int DCNTW = $clog2(DIVW + 1);
    localparam int QDEPTH = 2;
    localparam int QPTRW = $clog2(QDEPTH);
    localparam int QCNTW = $clog2(QDEPTH + 1);

    localparam logic [1:0] MODE_STRETCH = 2'd0;
    localparam logic [1:0] MODE_AREA = 2'd1;
    localparam logic [1:0] MODE_ANGLE = 2'd2;
    localparam logic [1:0] MODE_ISO = 2'd3;

    localparam logic [1:0] REG_MODE = 2'd0;
    localparam logic [1:0] REG_INPUT_AREA = 2'd1;
    localparam logic [1:0] REG_TARGET_AREA = 2'd2;

    typedef struct packed {
        logic [31:0] facet_area;
        logic [31:0] sing_first;
        logic [31:0] sing_second;
        logic        last_facet;
    } facet_t;

    typedef struct packed {
        logic [1:0]  metric_mode;
        logic [31:0] input_total_area;
        logic [31:0] target_total_area;
    } cfg_t;

    typedef struct packed {
        logic            start;
        logic [DIVW-1:0] num;
        logic [63:0]     den;
    } div_req_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [31:0] quot;
        logic        err;
    } div_rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ1,
        ST_SQ2,
        ST_SQ3,
        ST_PMUL,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_FSQ,
        ST_WMUL,
        ST_ACC
    } state_t;

    typedef enum logic [2:0] {
        OP_RECIP_P,
        OP_Q1,
        OP_Q2,
        OP_RECIP_S2,
        OP_MEAN,
        OP_RATIO,
        OP_METRIC,
        OP_FINAL
    } div_op_t;

endpackage

// ===== rtl/core/awdm_front.sv =====
// Input side: accepts facet items into a short queue for the back end.
module awdm_front (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  awdm_pkg::facet_t        s_item,
    output logic                    q_valid,
    output awdm_pkg::facet_t        q_item,
    input  logic                    q_pop
);
    import awdm_pkg::*;

    facet_t            mem_reg [QDEPTH];
    logic [QPTRW-1:0]  wr_ptr_reg;
    logic [QPTRW-1:0]  rd_ptr_reg;
    logic [QCNTW-1:0]  cnt_reg;
    logic              push;
    logic              pop;

    assign s_tready = (cnt_reg != QCNTW'(QDEPTH));
    assign push = s_tvalid && s_tready;
    assign q_valid = (cnt_reg != '0);
    assign pop = q_pop && q_valid;
    assign q_item = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= s_item;
        end
    end

endmodule

// ===== rtl/core/awdm_div.sv =====
// Bit-serial restoring divider with saturation to 32 bits and divide-by-zero flag.
module awdm_div (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  awdm_pkg::div_req_t   req,
    output awdm_pkg::div_rsp_t   rsp
);
    import awdm_pkg::*;

    logic [DIVW-1:0]  num_reg;
    logic [63:0]      den_reg;
    logic [63:0]      rem_reg;
    logic [31:0]      q_reg;
    logic             ovf_reg;
    logic [DCNTW-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [64:0]      rem_shift;
    logic             fits;

    assign rem_shift = {rem_reg, num_reg[DIVW-1]};
    assign fits = (rem_shift >= {1'b0, den_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else if (req.start) begin
            done_reg <= (req.den == '0);
            busy_reg <= (req.den != '0);
        end else if (busy_reg) begin
            if (cnt_reg == DCNTW'(1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            num_reg <= req.num;
            den_reg <= req.den;
            rem_reg <= '0;
            q_reg <= '0;
            ovf_reg <= (req.den == '0);
            cnt_reg <= DCNTW'(DIVW);
        end else if (busy_reg) begin
            num_reg <= num_reg << 1;
            rem_reg <= fits ? 64'(rem_shift - {1'b0, den_reg}) : rem_shift[63:0];
            q_reg <= {q_reg[30:0], fits};
            ovf_reg <= ovf_reg | q_reg[31];
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quot = ovf_reg ? 32'hFFFF_FFFF : q_reg;
    assign rsp.err = ovf_reg;

endmodule

// ===== rtl/core/awdm_back.sv =====
// Back end: per-facet term sequencer, weighted accumulation and final division.
module awdm_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  awdm_pkg::cfg_t    cfg,
    input  logic              q_valid,
    input  awdm_pkg::facet_t  q_item,
    output logic              q_pop,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [31:0]       m_tdata,
    output logic              m_tuser
);
    import awdm_pkg::*;

    state_t        state_reg;
    state_t        state_next;
    div_op_t       op_reg;
    facet_t        cur_reg;
    logic [63:0]   mul_reg;
    logic [63:0]   tmp_reg;
    logic [31:0]   term_reg;
    logic [31:0]   q1_reg;
    logic [31:0]   mean_reg;
    logic [63:0]   ws_reg;
    logic          err_reg;
    logic          out_valid_reg;
    logic [31:0]   out_data_reg;
    logic          out_err_reg;

    logic [31:0]   mul_x;
    logic [31:0]   mul_y;
    logic          mul_en;
    logic          out_free;
    logic          final_op;
    logic          out_load;
    div_req_t      dreq;
    div_rsp_t      drsp;

    logic [64:0]            sq_sum;
    logic [64:0]            sq_v;
    logic [64-FRAC_BITS:0]  ar_sum;
    logic [64-FRAC_BITS:0]  ar_half;
    logic [32:0]            an_sum;
    logic [64:0]            acc_sum;

    awdm_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (dreq),
        .rsp     (drsp)
    );

    assign out_free = !out_valid_reg || m_tready;
    assign final_op = (op_reg == OP_METRIC) || (op_reg == OP_FINAL);
    assign out_load = (state_reg == ST_DIV_WAIT) && drsp.done && final_op && out_free;

    assign sq_sum = {1'b0, tmp_reg} + {1'b0, mul_reg};
    assign sq_v = sq_sum >> (FRAC_BITS + 1);
    assign ar_sum = (65 - FRAC_BITS)'(mul_reg[63:FRAC_BITS]) + (65 - FRAC_BITS)'(drsp.quot);
    assign ar_half = ar_sum >> 1;
    assign an_sum = {1'b0, q1_reg} + {1'b0, drsp.quot};
    assign acc_sum = {1'b0, ws_reg} + 65'(mul_reg[63:FRAC_BITS]);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    case (cfg.metric_mode)
                        MODE_STRETCH: state_next = ST_SQ1;
                        MODE_AREA:    state_next = ST_PMUL;
                        default:      state_next = ST_DIV_GO;
                    endcase
                end
            end
            ST_SQ1:  state_next = ST_SQ2;
            ST_SQ2:  state_next = ST_SQ3;
            ST_SQ3:  state_next = ST_WMUL;
            ST_PMUL: state_next = ST_DIV_GO;
            ST_DIV_GO: state_next = ST_DIV_WAIT;
            ST_DIV_WAIT: begin
                if (drsp.done) begin
                    case (op_reg)
                        OP_Q1, OP_MEAN: state_next = ST_DIV_GO;
                        OP_RATIO:       state_next = ST_FSQ;
                        OP_METRIC, OP_FINAL: begin
                            if (out_free) begin
                                state_next = ST_IDLE;
                            end
                        end
                        default: state_next = ST_WMUL;
                    endcase
                end
            end
            ST_FSQ:  state_next = ST_DIV_GO;
            ST_WMUL: state_next = ST_ACC;
            ST_ACC:  state_next = cur_reg.last_facet ? ST_DIV_GO : ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        q_pop = 1'b0;
        mul_en = 1'b0;
        mul_x = cur_reg.sing_first;
        mul_y = cur_reg.sing_first;
        dreq.start = 1'b0;
        dreq.num = '0;
        dreq.den = '0;
        case (state_reg)
            ST_IDLE: q_pop = q_valid;
            ST_SQ1:  mul_en = 1'b1;
            ST_SQ2: begin
                mul_en = 1'b1;
                mul_x = cur_reg.sing_second;
                mul_y = cur_reg.sing_second;
            end
            ST_PMUL: begin
                mul_en = 1'b1;
                mul_y = cur_reg.sing_second;
            end
            ST_WMUL: begin
                mul_en = 1'b1;
                mul_x = cur_reg.facet_area;
                mul_y = term_reg;
            end
            ST_FSQ: begin
                mul_en = 1'b1;
                mul_x = mean_reg;
                mul_y = mean_reg;
            end
            ST_DIV_GO: begin
                dreq.start = 1'b1;
                case (op_reg)
                    OP_RECIP_P: begin
                        dreq.num = DIVW'(1) << (3 * FRAC_BITS);
                        dreq.den = mul_reg;
                    end
                    OP_Q1: begin
                        dreq.num = DIVW'(cur_reg.sing_first) << FRAC_BITS;
                        dreq.den = 64'(cur_reg.sing_second);
                    end
                    OP_Q2: begin
                        dreq.num = DIVW'(cur_reg.sing_second) << FRAC_BITS;
                        dreq.den = 64'(cur_reg.sing_first);
                    end
                    OP_RECIP_S2: begin
                        dreq.num = DIVW'(1) << (2 * FRAC_BITS);
                        dreq.den = 64'(cur_reg.sing_second);
                    end
                    OP_RATIO: begin
                        dreq.num = DIVW'(cfg.input_total_area) << FRAC_BITS;
                        dreq.den = 64'(cfg.target_total_area);
                    end
                    OP_METRIC: begin
                        dreq.num = DIVW'(q1_reg) << (2 * FRAC_BITS);
                        dreq.den = mul_reg;
                    end
                    default: begin
                        dreq.num = DIVW'(ws_reg) << FRAC_BITS;
                        dreq.den = 64'(cfg.input_total_area);
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ws_reg <= '0;
            err_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            out_valid_reg <= out_load || (out_valid_reg && !m_tready);
            case (state_reg)
                ST_SQ3: begin
                    if (|sq_v[64:32]) begin
                        err_reg <= 1'b1;
                    end
                end
                ST_ACC: begin
                    if (acc_sum[64]) begin
                        ws_reg <= '1;
                        err_reg <= 1'b1;
                    end else begin
                        ws_reg <= acc_sum[63:0];
                    end
                end
                ST_DIV_WAIT: begin
                    if (drsp.done) begin
                        if (final_op) begin
                            if (out_free) begin
                                ws_reg <= '0;
                                err_reg <= 1'b0;
                            end
                        end else begin
                            if (drsp.err || ((op_reg == OP_RECIP_P) &&
                                             (|ar_half[64-FRAC_BITS:32]))) begin
                                err_reg <= 1'b1;
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && q_valid) begin
            cur_reg <= q_item;
            op_reg <= (cfg.metric_mode == MODE_ANGLE) ? OP_Q1 : OP_RECIP_S2;
        end
        if (mul_en) begin
            mul_reg <= mul_x * mul_y;
        end
        case (state_reg)
            ST_SQ2:  tmp_reg <= mul_reg;
            ST_SQ3:  term_reg <= (|sq_v[64:32]) ? 32'hFFFF_FFFF : sq_v[31:0];
            ST_PMUL: op_reg <= OP_RECIP_P;
            ST_FSQ:  op_reg <= OP_METRIC;
            ST_ACC:  op_reg <= (cfg.metric_mode == MODE_STRETCH) ? OP_MEAN : OP_FINAL;
            ST_DIV_WAIT: begin
                if (drsp.done) begin
                    case (op_reg)
                        OP_RECIP_P: begin
                            term_reg <= (|ar_half[64-FRAC_BITS:32]) ? 32'hFFFF_FFFF
                                                                    : ar_half[31:0];
                        end
                        OP_Q1: begin
                            q1_reg <= drsp.quot;
                            op_reg <= OP_Q2;
                        end
                        OP_Q2: term_reg <= an_sum[32:1];
                        OP_RECIP_S2: begin
                            term_reg <= (cur_reg.sing_first > drsp.quot) ?
                                        cur_reg.sing_first : drsp.quot;
                        end
                        OP_MEAN: begin
                            mean_reg <= drsp.quot;
                            op_reg <= OP_RATIO;
                        end
                        OP_RATIO: q1_reg <= drsp.quot;
                        default: begin
                            if (out_free) begin
                                out_data_reg <= drsp.quot;
                                out_err_reg <= err_reg | drsp.err;
                            end
                        end
                    endcase
                end
            end
            default: begin
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata = out_data_reg;
    assign m_tuser = out_err_reg;

endmodule

// ===== rtl/core/area_weighted_distortion_metric.sv =====
// Top level of the area-weighted distortion metric: register port, front queue, back end.
// A facet needs no division in stretch mode, one in area and isometric mode and two in angle
// mode, each on the one-bit-a-cycle divider of 112 steps per quotient.
// A last facet adds one final quotient (three in stretch mode, with a square) before its
// item appears; input items queue two deep meanwhile.
// Reset is synchronous, active low; it clears the queue, sum, error flag and registers.
module area_weighted_distortion_metric (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // facet_area, sing_first, sing_second
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // metric_value
    output logic        m_tuser,   // error_flag
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import awdm_pkg::*;

    cfg_t    cfg_reg;
    facet_t  s_item;
    facet_t  q_item;
    logic    q_valid;
    logic    q_pop;
    logic    wr_en;

    assign pready = 1'b1;
    assign wr_en = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.metric_mode <= MODE_AREA;
            cfg_reg.input_total_area <= 32'(1) << FRAC_BITS;
            cfg_reg.target_total_area <= 32'(1) << FRAC_BITS;
        end else if (wr_en) begin
            case (paddr[3:2])
                REG_MODE:        cfg_reg.metric_mode <= pwdata[1:0];
                REG_INPUT_AREA:  cfg_reg.input_total_area <= pwdata;
                REG_TARGET_AREA: cfg_reg.target_total_area <= pwdata;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_MODE:        prdata = {30'd0, cfg_reg.metric_mode};
            REG_INPUT_AREA:  prdata = cfg_reg.input_total_area;
            REG_TARGET_AREA: prdata = cfg_reg.target_total_area;
            default:         prdata = '0;
        endcase
    end

    assign s_item.facet_area = s_tdata[31:0];
    assign s_item.sing_first = s_tdata[63:32];
    assign s_item.sing_second = s_tdata[95:64];
    assign s_item.last_facet = s_tlast;

    awdm_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_item   (s_item),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    awdm_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

// ===== rtl/core/awdm_checker.sv =====
// Port-level checks on the distortion metric block and the bind that attaches them.
module awdm_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tuser,
    input logic        pready
);

    a_reset_clears_out: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_pready_high: assert property (@(posedge aclk) pready)
        else $error("pready dropped");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result item changed");

endmodule

bind area_weighted_distortion_metric awdm_checker u_awdm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .pready   (pready)
);
